>>> hw/rtl/osm_pkg.sv
`timescale 1ns / 1ps

package osm_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_HEADER  = 1'b0;
	localparam logic OP_ELEMENT = 1'b1;

	localparam logic [23:0] ONE_Q1_23 = 24'h800000;
	localparam logic [30:0] EXP_LIMIT = 31'h41000000;

	typedef struct packed {
		logic        op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} osm_item_t;

	localparam logic [23:0] EXP_TAB [257] = '{
		24'h800000, 24'h7c0fd6, 24'h783eb0, 24'h748b9b, 24'h70f5a9, 24'h6d7bf5,
		24'h6a1da0, 24'h66d9d4, 24'h63afbe, 24'h609e96, 24'h5da595, 24'h5ac3fe,
		24'h57f918, 24'h554432, 24'h52a49c, 24'h5019b1, 24'h4da2cc, 24'h4b3f50,
		24'h48eea5, 24'h46b035, 24'h448372, 24'h4267d0, 24'h405cc9, 24'h3e61d9,
		24'h3c7682, 24'h3a9a49, 24'h38ccb6, 24'h370d57, 24'h355bbc, 24'h33b778,
		24'h322022, 24'h309554, 24'h2f16ac, 24'h2da3ca, 24'h2c3c51, 24'h2adfe8,
		24'h298e36, 24'h2846e9, 24'h2709ad, 24'h25d634, 24'h24ac30, 24'h238b58,
		24'h227363, 24'h21640b, 24'h205d0c, 24'h1f5e25, 24'h1e6715, 24'h1d779f,
		24'h1c8f87, 24'h1bae94, 24'h1ad48c, 24'h1a0139, 24'h193467, 24'h186de2,
		24'h17ad78, 24'h16f2fb, 24'h163e39, 24'h158f08, 24'h14e53b, 24'h1440a7,
		24'h13a123, 24'h130687, 24'h1270ae, 24'h11df70, 24'h1152ab, 24'h10ca3a,
		24'h1045fc, 24'h0fc5cf, 24'h0f4994, 24'h0ed12c, 24'h0e5c78, 24'h0deb5b,
		24'h0d7db9, 24'h0d1376, 24'h0cac79, 24'h0c48a6, 24'h0be7e6, 24'h0b8a20,
		24'h0b2f3c, 24'h0ad725, 24'h0a81c3, 24'h0a2f02, 24'h09decc, 24'h09910e,
		24'h0945b5, 24'h08fcad, 24'h08b5e4, 24'h087149, 24'h082eca, 24'h07ee57,
		24'h07afdf, 24'h077354, 24'h0738a5, 24'h06ffc4, 24'h06c8a4, 24'h069336,
		24'h065f6c, 24'h062d3b, 24'h05fc94, 24'h05cd6d, 24'h059fba, 24'h05736e,
		24'h05487f, 24'h051ee3, 24'h04f68e, 24'h04cf76, 24'h04a993, 24'h0484da,
		24'h046142, 24'h043ec3, 24'h041d53, 24'h03fceb, 24'h03dd82, 24'h03bf10,
		24'h03a18e, 24'h0384f5, 24'h03693d, 24'h034e5f, 24'h033455, 24'h031b18,
		24'h0302a1, 24'h02eaeb, 24'h02d3f0, 24'h02bdab, 24'h02a814, 24'h029328,
		24'h027ee0, 24'h026b38, 24'h02582b, 24'h0245b4, 24'h0233ce, 24'h022275,
		24'h0211a5, 24'h02015a, 24'h01f18e, 24'h01e23f, 24'h01d369, 24'h01c508,
		24'h01b717, 24'h01a995, 24'h019c7d, 24'h018fcc, 24'h01837f, 24'h017793,
		24'h016c05, 24'h0160d2, 24'h0155f7, 24'h014b72, 24'h01413f, 24'h01375d,
		24'h012dc8, 24'h01247f, 24'h011b80, 24'h0112c7, 24'h010a53, 24'h010221,
		24'h00fa30, 24'h00f27d, 24'h00eb07, 24'h00e3cc, 24'h00dcca, 24'h00d5ff,
		24'h00cf6a, 24'h00c908, 24'h00c2d8, 24'h00bcda, 24'h00b70a, 24'h00b169,
		24'h00abf3, 24'h00a6a9, 24'h00a188, 24'h009c90, 24'h0097bf, 24'h009314,
		24'h008e8d, 24'h008a2b, 24'h0085ea, 24'h0081cc, 24'h007dcd, 24'h0079ee,
		24'h00762e, 24'h00728b, 24'h006f05, 24'h006b9b, 24'h00684b, 24'h006516,
		24'h0061f9, 24'h005ef6, 24'h005c0a, 24'h005935, 24'h005676, 24'h0053cd,
		24'h005139, 24'h004eba, 24'h004c4d, 24'h0049f4, 24'h0047ae, 24'h004579,
		24'h004356, 24'h004144, 24'h003f42, 24'h003d50, 24'h003b6d, 24'h003999,
		24'h0037d3, 24'h00361b, 24'h003471, 24'h0032d4, 24'h003144, 24'h002fc0,
		24'h002e48, 24'h002cdb, 24'h002b7a, 24'h002a23, 24'h0028d8, 24'h002796,
		24'h00265e, 24'h002530, 24'h00240b, 24'h0022ef, 24'h0021dc, 24'h0020d1,
		24'h001fcf, 24'h001ed4, 24'h001de1, 24'h001cf6, 24'h001c12, 24'h001b35,
		24'h001a5f, 24'h00198f, 24'h0018c6, 24'h001802, 24'h001745, 24'h00168e,
		24'h0015dc, 24'h001530, 24'h001489, 24'h0013e8, 24'h00134b, 24'h0012b3,
		24'h001220, 24'h001191, 24'h001107, 24'h001080, 24'h000ffe, 24'h000f80,
		24'h000f06, 24'h000e90, 24'h000e1d, 24'h000dae, 24'h000d42, 24'h000cda,
		24'h000c75, 24'h000c13, 24'h000bb4, 24'h000b57, 24'h000afe
	};

	localparam logic [23:0] RECIP_TAB [257] = '{
		24'h800000, 24'h7f8080, 24'h7f01fc, 24'h7e8473, 24'h7e07e0, 24'h7d8c43,
		24'h7d1196, 24'h7c97d9, 24'h7c1f08, 24'h7ba720, 24'h7b301f, 24'h7aba02,
		24'h7a44c7, 24'h79d06b, 24'h795ceb, 24'h78ea46, 24'h787878, 24'h780780,
		24'h77975c, 24'h772807, 24'h76b982, 24'h764bc9, 24'h75ded9, 24'h7572b2,
		24'h750750, 24'h749cb3, 24'h7432d6, 24'h73c9b9, 24'h73615a, 24'h72f9b6,
		24'h7292cc, 24'h722c99, 24'h71c71c, 24'h716253, 24'h70fe3c, 24'h709ad5,
		24'h70381c, 24'h6fd610, 24'h6f74ae, 24'h6f13f6, 24'h6eb3e4, 24'h6e5479,
		24'h6df5b1, 24'h6d978c, 24'h6d3a07, 24'h6cdd21, 24'h6c80d9, 24'h6c252d,
		24'h6bca1b, 24'h6b6fa2, 24'h6b15c0, 24'h6abc75, 24'h6a63be, 24'h6a0b99,
		24'h69b407, 24'h695d04, 24'h690690, 24'h68b0aa, 24'h685b50, 24'h680680,
		24'h67b23a, 24'h675e7c, 24'h670b45, 24'h66b894, 24'h666666, 24'h6614bc,
		24'h65c394, 24'h6572ec, 24'h6522c4, 24'h64d31a, 24'h6483ed, 24'h64353c,
		24'h63e706, 24'h63994a, 24'h634c06, 24'h62ff3a, 24'h62b2e4, 24'h626704,
		24'h621b98, 24'h61d09f, 24'h618618, 24'h613c03, 24'h60f25e, 24'h60a928,
		24'h606060, 24'h601806, 24'h5fd018, 24'h5f8895, 24'h5f417d, 24'h5eface,
		24'h5eb488, 24'h5e6eaa, 24'h5e2932, 24'h5de420, 24'h5d9f74, 24'h5d5b2b,
		24'h5d1746, 24'h5cd3c3, 24'h5c90a2, 24'h5c4de2, 24'h5c0b81, 24'h5bc980,
		24'h5b87de, 24'h5b4699, 24'h5b05b0, 24'h5ac524, 24'h5a84f3, 24'h5a451d,
		24'h5a05a0, 24'h59c67d, 24'h5987b2, 24'h59493e, 24'h590b21, 24'h58cd5b,
		24'h588fea, 24'h5852ce, 24'h581606, 24'h57d991, 24'h579d6f, 24'h57619f,
		24'h572621, 24'h56eaf3, 24'h56b016, 24'h567588, 24'h563b49, 24'h560158,
		24'h55c7b5, 24'h558e5f, 24'h555555, 24'h551c98, 24'h54e425, 24'h54abfd,
		24'h547420, 24'h543c8c, 24'h540540, 24'h53ce3e, 24'h539783, 24'h53610f,
		24'h532ae2, 24'h52f4fb, 24'h52bf5b, 24'h5289ff, 24'h5254e8, 24'h522015,
		24'h51eb85, 24'h51b739, 24'h51832f, 24'h514f68, 24'h511be2, 24'h50e89d,
		24'h50b599, 24'h5082d5, 24'h505050, 24'h501e0b, 24'h4fec05, 24'h4fba3d,
		24'h4f88b3, 24'h4f5766, 24'h4f2657, 24'h4ef583, 24'h4ec4ec, 24'h4e9491,
		24'h4e6471, 24'h4e348b, 24'h4e04e0, 24'h4dd56f, 24'h4da638, 24'h4d7739,
		24'h4d4874, 24'h4d19e7, 24'h4ceb91, 24'h4cbd74, 24'h4c8f8d, 24'h4c61dd,
		24'h4c3464, 24'h4c0721, 24'h4bda13, 24'h4bad3b, 24'h4b8097, 24'h4b5428,
		24'h4b27ed, 24'h4afbe6, 24'h4ad013, 24'h4aa472, 24'h4a7905, 24'h4a4dc9,
		24'h4a22c0, 24'h49f7e9, 24'h49cd43, 24'h49a2ce, 24'h49788a, 24'h494e76,
		24'h492492, 24'h48fade, 24'h48d15a, 24'h48a805, 24'h487ede, 24'h4855e6,
		24'h482d1c, 24'h480480, 24'h47dc12, 24'h47b3d1, 24'h478bbd, 24'h4763d6,
		24'h473c1b, 24'h47148c, 24'h46ed29, 24'h46c5f2, 24'h469ee6, 24'h467804,
		24'h46514e, 24'h462ac2, 24'h460460, 24'h45de28, 24'h45b81a, 24'h459235,
		24'h456c79, 24'h4546e7, 24'h45217c, 24'h44fc3a, 24'h44d720, 24'h44b22e,
		24'h448d64, 24'h4468c0, 24'h444444, 24'h441fef, 24'h43fbc0, 24'h43d7b8,
		24'h43b3d6, 24'h439019, 24'h436c83, 24'h434911, 24'h4325c5, 24'h43029e,
		24'h42df9c, 24'h42bcbe, 24'h429a04, 24'h42776f, 24'h4254fd, 24'h4232af,
		24'h421084, 24'h41ee7d, 24'h41cc98, 24'h41aad6, 24'h418937, 24'h4167bb,
		24'h414660, 24'h412527, 24'h410410, 24'h40e31b, 24'h40c247, 24'h40a194,
		24'h408102, 24'h406091, 24'h404040, 24'h402010, 24'h400000
	};

	function automatic logic [47:0] fp_to_mag48(input logic [31:0] bits);
		logic [47:0] sig;
		logic [7:0]  e;
		logic [47:0] r;
		sig = {24'b0, 1'b1, bits[22:0]};
		e = bits[30:23];
		r = '0;
		if (bits[30:0] != '0) begin
			if (e >= 8'd166) begin
				r = '0;
			end else if (e >= 8'd118) begin
				r = sig << (e - 8'd118);
			end else if ((8'd118 - e) < 8'd24) begin
				r = sig >> (8'd118 - e);
			end
		end
		return r;
	endfunction

	function automatic logic [50:0] fp_to_sq(input logic [31:0] bits);
		logic [50:0] m;
		m = {3'b0, fp_to_mag48(bits)};
		return bits[31] ? (~m + 51'd1) : m;
	endfunction

	function automatic logic [5:0] lead_one(input logic [47:0] v);
		logic [5:0] m;
		m = '0;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) begin
				m = 6'(i);
			end
		end
		return m;
	endfunction

	function automatic logic [31:0] mag_to_fp(input logic [47:0] v, input logic nz);
		logic [5:0]  msb;
		logic [47:0] n;
		msb = lead_one(v);
		if (msb >= 6'd23) begin
			n = v >> (msb - 6'd23);
		end else begin
			n = v << (6'd23 - msb);
		end
		return nz ? {1'b0, 8'(msb) + 8'd95, n[22:0]} : 32'd0;
	endfunction

	function automatic logic [31:0] sq_to_fp(input logic [50:0] s);
		logic [50:0] m;
		logic [31:0] f;
		m = s[50] ? (~s + 51'd1) : s;
		f = mag_to_fp(m[47:0], s != '0);
		return {s[50], f[30:0]};
	endfunction

	function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka;
		logic [31:0] kb;
		ka = a[31] ? ~a : (a | 32'h80000000);
		kb = b[31] ? ~b : (b | 32'h80000000);
		if (a[30:0] > 31'h7f800000 || b[30:0] > 31'h7f800000) begin
			return 1'b0;
		end
		if (a[30:0] == '0 && b[30:0] == '0) begin
			return 1'b0;
		end
		return ka > kb;
	endfunction

	function automatic logic [23:0] exp_q(input logic [31:0] bits);
		logic [7:0]  e;
		logic [7:0]  sh;
		logic [40:0] t;
		logic [17:0] pos;
		logic [8:0]  idx;
		logic [8:0]  idx_hi;
		logic [23:0] lo;
		logic [23:0] hi;
		logic [23:0] diff;
		logic [31:0] prod;
		e = bits[30:23];
		sh = e - 8'd114;
		t = {17'b0, 1'b1, bits[22:0]} << sh[4:0];
		pos = '0;
		if (e >= 8'd114) begin
			pos = (sh >= 8'd17) ? 18'd65536 : t[40:23];
		end
		idx = (pos[17:8] > 10'd256) ? 9'd256 : pos[16:8];
		idx_hi = (idx == 9'd256) ? 9'd256 : idx + 9'd1;
		lo = EXP_TAB[idx];
		hi = EXP_TAB[idx_hi];
		diff = lo - hi;
		prod = diff * pos[7:0];
		if (e == 8'hff) begin
			return '0;
		end
		if (bits[30:0] == '0 || !bits[31]) begin
			return ONE_Q1_23;
		end
		if (bits[30:0] > EXP_LIMIT) begin
			return '0;
		end
		return lo - prod[31:8];
	endfunction

	function automatic logic [23:0] recip_q(input logic [31:0] ln);
		logic [23:0] rlo;
		logic [23:0] rhi;
		logic [23:0] diff;
		logic [38:0] prod;
		rlo = RECIP_TAB[{1'b0, ln[22:15]}];
		rhi = RECIP_TAB[{1'b0, ln[22:15]} + 9'd1];
		diff = rlo - rhi;
		prod = diff * ln[14:0];
		return rlo - prod[38:15];
	endfunction

	function automatic logic [47:0] mul_q1_23(input logic [47:0] lhs, input logic [23:0] rhs);
		logic [47:0] ph;
		logic [47:0] pl;
		ph = lhs[47:24] * rhs;
		pl = lhs[23:0] * rhs;
		return {ph[46:0], 1'b0} + {23'b0, pl[47:23]};
	endfunction

	function automatic logic [47:0] scale48(input logic [47:0] s, input logic signed [8:0] sc);
		logic [8:0] nsc;
		nsc = -sc;
		if (sc > 9'sd0) begin
			return (sc >= 9'sd48) ? 48'd0 : (s << sc);
		end
		if (sc <= -9'sd64) begin
			return '0;
		end
		return s >> nsc;
	endfunction

	function automatic logic [50:0] weight_fin(input logic [63:0] p1, input logic [47:0] m,
		input logic [47:0] w, input logic neg);
		logic [47:0] t1;
		logic [47:0] t2;
		logic [31:0] t4;
		logic [47:0] s;
		t1 = m[47:32] * w[31:0];
		t2 = w[47:32] * m[31:0];
		t4 = m[47:32] * w[47:32];
		s = {16'b0, p1[63:32]} + t1 + t2 + {t4[15:0], 32'b0};
		return neg ? (~{3'b0, s} + 51'd1) : {3'b0, s};
	endfunction

endpackage

>>> hw/rtl/osm_item_if.sv
`timescale 1ns / 1ps

interface osm_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] old_max_bits;
	logic [31:0] old_sum_bits;
	logic [31:0] tile_max_bits;
	logic [31:0] tile_sum_bits;
	logic [31:0] old_value_bits;
	logic [31:0] tile_value_bits;

	modport source (output valid, operation, old_max_bits, old_sum_bits, tile_max_bits,
		tile_sum_bits, old_value_bits, tile_value_bits, input ready);
	modport sink (input valid, operation, old_max_bits, old_sum_bits, tile_max_bits,
		tile_sum_bits, old_value_bits, tile_value_bits, output ready);
endinterface

>>> hw/rtl/osm_result_if.sv
`timescale 1ns / 1ps

interface osm_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] new_max_bits;
	logic [31:0] new_sum_bits;
	logic [31:0] merged_value_bits;

	modport source (output valid, result_kind, new_max_bits, new_sum_bits,
		merged_value_bits, input ready);
	modport sink (input valid, result_kind, new_max_bits, new_sum_bits,
		merged_value_bits, output ready);
endinterface

>>> hw/rtl/osm_front.sv
`timescale 1ns / 1ps

module osm_front import osm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	osm_item_if.sink  item,
	output logic      q_valid,
	output osm_item_t q_item,
	input  logic      q_pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	osm_item_t      entry_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	osm_item_t      in_item;
	logic           push;

	assign item.ready = (cnt_q != CW'(DEPTH));
	assign push = item.valid && item.ready;
	assign q_valid = (cnt_q != '0);
	assign q_item = entry_q[rd_q];

	always_comb begin
		in_item.op = item.operation;
		if (item.operation == OP_HEADER) begin
			in_item.a = item.old_max_bits;
			in_item.b = item.old_sum_bits;
			in_item.c = item.tile_max_bits;
			in_item.d = item.tile_sum_bits;
		end else begin
			in_item.a = item.old_value_bits;
			in_item.b = item.tile_value_bits;
			in_item.c = '0;
			in_item.d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (q_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/osm_back.sv
`timescale 1ns / 1ps

module osm_back import osm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  osm_item_t  q_item,
	output logic       q_pop,
	osm_result_if.source result
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_HCONV = 4'd1;
	localparam logic [3:0] ST_HEXP  = 4'd2;
	localparam logic [3:0] ST_HSO   = 4'd3;
	localparam logic [3:0] ST_HST   = 4'd4;
	localparam logic [3:0] ST_HLN   = 4'd5;
	localparam logic [3:0] ST_HRC   = 4'd6;
	localparam logic [3:0] ST_HWO   = 4'd7;
	localparam logic [3:0] ST_HWT   = 4'd8;
	localparam logic [3:0] ST_EOLO  = 4'd9;
	localparam logic [3:0] ST_EOHI  = 4'd10;
	localparam logic [3:0] ST_ETLO  = 4'd11;
	localparam logic [3:0] ST_ETHI  = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	logic [3:0]        state_q;
	logic              op_q;
	logic [31:0]       mn_q;
	logic [50:0]       d_o_q;
	logic [50:0]       d_t_q;
	logic [47:0]       x_q;
	logic [47:0]       y_q;
	logic              neg_o_q;
	logic              neg_t_q;
	logic [31:0]       fo_q;
	logic [31:0]       ft_q;
	logic [23:0]       eo_q;
	logic [23:0]       et_q;
	logic [47:0]       so_q;
	logic [47:0]       st_q;
	logic [31:0]       ln_q;
	logic [23:0]       rc_q;
	logic signed [8:0] sc_q;
	logic [47:0]       old_w_q;
	logic [47:0]       tile_w_q;
	logic [63:0]       p1_q;
	logic [50:0]       a_q;
	logic [50:0]       b_q;
	logic              out_valid_q;
	logic              out_kind_q;
	logic [31:0]       out_max_q;
	logic [31:0]       out_sum_q;
	logic [31:0]       out_merged_q;
	logic [31:0]       mn;
	logic [47:0]       sum48;
	logic              load_out;

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	assign mn = fp_greater(q_item.a, q_item.c) ? q_item.a : q_item.c;
	assign sum48 = so_q + st_q;

	assign result.valid = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.new_max_bits = out_max_q;
	assign result.new_sum_bits = out_sum_q;
	assign result.merged_value_bits = out_merged_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= q_item.op;
				mn_q <= mn;
				d_o_q <= fp_to_sq(q_item.a) - fp_to_sq(mn);
				d_t_q <= fp_to_sq(q_item.c) - fp_to_sq(mn);
				neg_o_q <= q_item.a[31];
				neg_t_q <= q_item.b[31];
				if (q_item.op == OP_HEADER) begin
					x_q <= fp_to_mag48(q_item.b);
					y_q <= fp_to_mag48(q_item.d);
				end else begin
					x_q <= fp_to_mag48(q_item.a);
					y_q <= fp_to_mag48(q_item.b);
				end
			end
			ST_HCONV: begin
				fo_q <= sq_to_fp(d_o_q);
				ft_q <= sq_to_fp(d_t_q);
			end
			ST_HEXP: begin
				eo_q <= exp_q(fo_q);
				et_q <= exp_q(ft_q);
			end
			ST_HSO: so_q <= mul_q1_23(x_q, eo_q);
			ST_HST: st_q <= mul_q1_23(y_q, et_q);
			ST_HLN: ln_q <= mag_to_fp(sum48, sum48 != '0);
			ST_HRC: begin
				rc_q <= recip_q(ln_q);
				sc_q <= 9'sd127 - signed'({1'b0, ln_q[30:23]});
			end
			ST_EOLO: p1_q <= x_q[31:0] * old_w_q[31:0];
			ST_EOHI: a_q <= weight_fin(p1_q, x_q, old_w_q, neg_o_q);
			ST_ETLO: p1_q <= y_q[31:0] * tile_w_q[31:0];
			ST_ETHI: b_q <= weight_fin(p1_q, y_q, tile_w_q, neg_t_q);
			default: begin
			end
		endcase
		if (load_out) begin
			out_kind_q <= op_q;
			if (op_q == OP_HEADER) begin
				out_max_q <= mn_q;
				out_sum_q <= ln_q;
				out_merged_q <= '0;
			end else begin
				out_max_q <= '0;
				out_sum_q <= '0;
				out_merged_q <= sq_to_fp(a_q + b_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			old_w_q <= '0;
			tile_w_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= (q_item.op == OP_HEADER) ? ST_HCONV : ST_EOLO;
					end
				end
				ST_HCONV: state_q <= ST_HEXP;
				ST_HEXP:  state_q <= ST_HSO;
				ST_HSO:   state_q <= ST_HST;
				ST_HST:   state_q <= ST_HLN;
				ST_HLN:   state_q <= ST_HRC;
				ST_HRC:   state_q <= ST_HWO;
				ST_HWO: begin
					old_w_q <= scale48(mul_q1_23(so_q, rc_q), sc_q);
					state_q <= ST_HWT;
				end
				ST_HWT: begin
					tile_w_q <= scale48(mul_q1_23(st_q, rc_q), sc_q);
					state_q <= ST_DONE;
				end
				ST_EOLO: state_q <= ST_EOHI;
				ST_EOHI: state_q <= ST_ETLO;
				ST_ETLO: state_q <= ST_ETHI;
				ST_ETHI: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_IDLE)
		else $error("queue pop outside idle");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> result.valid)
		else $error("finished item not presented");

	a_header_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HWT |=> state_q == ST_DONE && op_q == OP_HEADER)
		else $error("header sequence broken");

endmodule

>>> hw/rtl/online_softmax_merge_core.sv
`timescale 1ns / 1ps
// Header items step through HCONV, HEXP, HSO, HST, HLN, HRC, HWO and HWT; element items through
// EOLO, EOHI, ETLO and ETHI. Both then wait in DONE until the result register is free or being taken.
// A single multi-step sequencer evaluates one item at a time and pops the queue only when idle.
// The two-entry input queue keeps accepting while the sequencer works or a result waits, until full.
// Asynchronous active-low reset empties the queue, idles the sequencer and zeroes both weights.
module online_softmax_merge_core import osm_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	osm_item_if.sink     item,
	osm_result_if.source result
);

	logic      q_valid;
	osm_item_t q_item;
	logic      q_pop;

	osm_front #(.DEPTH(QDEPTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	osm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

>>> tb/online_softmax_merge_core_tb.sv
`timescale 1ns / 1ps

module online_softmax_merge_core_tb;
	import osm_pkg::*;

	localparam logic [63:0] MASK48 = 64'h0000ffffffffffff;
	localparam logic [31:0] POS_INF = 32'h7f800000;
	localparam logic [31:0] QNAN = 32'h7fc00000;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic        op;
		logic [31:0] old_max;
		logic [31:0] old_sum;
		logic [31:0] tile_max;
		logic [31:0] tile_sum;
		logic [31:0] old_val;
		logic [31:0] tile_val;
	} merge_item_t;

	typedef struct {
		logic        kind;
		logic [31:0] new_max;
		logic [31:0] new_sum;
		logic [31:0] merged;
	} merge_result_t;

	logic clk;
	logic arst_n;
	int   cycles;
	int   failures;
	int   src_idle;
	int   snk_idle;
	logic [63:0] old_w;
	logic [63:0] tile_w;
	merge_result_t pending_results[$];

	osm_item_if   item_ch();
	osm_result_if result_ch();

	online_softmax_merge_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] fix_mag(input logic [31:0] b);
		logic [63:0] sig;
		int          sh;
		if (b[30:0] == '0) return 64'd0;
		sig = {40'd0, 1'b1, b[22:0]};
		sh = int'(b[30:23]) - 118;
		if (sh >= 48) return 64'd0;
		if (sh >= 0) return (sig << sh) & MASK48;
		if (sh <= -64) return 64'd0;
		return sig >> (-sh);
	endfunction

	function automatic logic [63:0] fix_signed(input logic [31:0] b);
		logic [63:0] m;
		m = fix_mag(b);
		return b[31] ? (64'd0 - m) : m;
	endfunction

	function automatic logic [31:0] float_of_mag(input logic [63:0] v);
		int          msb;
		logic [63:0] norm;
		msb = 0;
		if (v == 64'd0) return 32'd0;
		for (int i = 0; i < 48; i++) if (v[i]) msb = i;
		norm = (msb >= 23) ? (v >> (msb - 23)) : (v << (23 - msb));
		return (32'(msb + 95) << 23) | {9'd0, norm[22:0]};
	endfunction

	function automatic logic [31:0] float_of_signed(input logic [63:0] v);
		if (v[63]) return 32'h80000000 | float_of_mag(64'd0 - v);
		return float_of_mag(v);
	endfunction

	function automatic logic float_gt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka;
		logic [31:0] kb;
		if (a[30:0] > 31'h7f800000 || b[30:0] > 31'h7f800000) return 1'b0;
		if (a[30:0] == '0 && b[30:0] == '0) return 1'b0;
		ka = a[31] ? ~a : (a | 32'h80000000);
		kb = b[31] ? ~b : (b | 32'h80000000);
		return ka > kb;
	endfunction

	function automatic logic [31:0] exp_fix(input logic [31:0] b);
		logic [31:0] e;
		logic [31:0] pos;
		logic [31:0] idx;
		logic [31:0] frac;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [63:0] sig;
		int          sh;
		e = {24'd0, b[30:23]};
		if (e == 32'd255) return 32'd0;
		if (b[30:0] == '0 || !b[31]) return 32'h800000;
		if ({1'b0, b[30:0]} > 32'h41000000) return 32'd0;
		pos = 32'd0;
		if (e != 32'd0) begin
			sh = int'(e) - 114;
			sig = {40'd0, 1'b1, b[22:0]};
			if (sh >= 17) pos = 32'd65536;
			else if (sh >= 0) pos = 32'((sig << sh) >> 23);
		end
		idx = pos >> 8;
		if (idx > 32'd256) idx = 32'd256;
		frac = pos & 32'hff;
		lo = {8'd0, EXP_TAB[idx]};
		hi = (idx == 32'd256) ? lo : {8'd0, EXP_TAB[idx + 1]};
		return lo - (((lo - hi) * frac) >> 8);
	endfunction

	function automatic logic [63:0] mul_fix(input logic [63:0] lhs, input logic [63:0] rhs);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] r;
		lo = lhs & 64'hffffff;
		hi = (lhs >> 24) & 64'hffffff;
		r = (hi * rhs) << 1;
		r = r + ((lo * rhs) >> 23);
		return r & MASK48;
	endfunction

	function automatic logic [63:0] scale_fix(input logic [63:0] lhs, input logic [63:0] rhs,
		input int sc);
		logic [63:0] s;
		s = mul_fix(lhs, rhs);
		if (sc > 0) return (sc >= 48) ? 64'd0 : ((s << sc) & MASK48);
		if (sc <= -64) return 64'd0;
		return s >> (-sc);
	endfunction

	function automatic logic [63:0] weigh(input logic [63:0] v, input logic [63:0] w);
		logic        neg;
		logic [63:0] m;
		logic [63:0] s;
		neg = v[63];
		m = neg ? (64'd0 - v) : v;
		s = ((m & 64'hffffffff) * (w & 64'hffffffff)) >> 32;
		s = s + ((m >> 32) & 64'hffff) * (w & 64'hffffffff);
		s = s + ((w >> 32) & 64'hffff) * (m & 64'hffffffff);
		s = s + ((((m >> 32) & 64'hffff) * ((w >> 32) & 64'hffff)) << 32);
		s = s & MASK48;
		return neg ? (64'd0 - s) : s;
	endfunction

	task automatic predict_merge(input merge_item_t it);
		merge_result_t r;
		logic [31:0]   mn;
		logic [63:0]   mnq;
		logic [31:0]   eo;
		logic [31:0]   et;
		logic [63:0]   so;
		logic [63:0]   st;
		logic [31:0]   ln;
		logic [31:0]   fr;
		logic [31:0]   rlo;
		logic [31:0]   rhi;
		logic [31:0]   rc;
		int            sc;
		r.kind = it.op;
		r.new_max = 32'd0;
		r.new_sum = 32'd0;
		r.merged = 32'd0;
		if (it.op == OP_HEADER) begin
			mn = float_gt(it.old_max, it.tile_max) ? it.old_max : it.tile_max;
			mnq = fix_signed(mn);
			eo = exp_fix(float_of_signed(fix_signed(it.old_max) - mnq));
			et = exp_fix(float_of_signed(fix_signed(it.tile_max) - mnq));
			so = mul_fix(fix_mag(it.old_sum), {32'd0, eo});
			st = mul_fix(fix_mag(it.tile_sum), {32'd0, et});
			ln = float_of_mag((so + st) & MASK48);
			fr = ln & 32'h7fff;
			rlo = {8'd0, RECIP_TAB[ln[22:15]]};
			rhi = {8'd0, RECIP_TAB[{1'b0, ln[22:15]} + 9'd1]};
			rc = rlo - (((rlo - rhi) * fr) >> 15);
			sc = 127 - int'(ln[30:23]);
			old_w = scale_fix(so, {32'd0, rc}, sc);
			tile_w = scale_fix(st, {32'd0, rc}, sc);
			r.new_max = mn;
			r.new_sum = ln;
		end else begin
			r.merged = float_of_signed(weigh(fix_signed(it.old_val), old_w) +
				weigh(fix_signed(it.tile_val), tile_w));
		end
		pending_results.push_back(r);
	endtask

	task automatic send_item(input merge_item_t it);
		while ($urandom_range(0, 99) < src_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid           <= 1'b1;
		item_ch.operation       <= it.op;
		item_ch.old_max_bits    <= it.old_max;
		item_ch.old_sum_bits    <= it.old_sum;
		item_ch.tile_max_bits   <= it.tile_max;
		item_ch.tile_sum_bits   <= it.tile_sum;
		item_ch.old_value_bits  <= it.old_val;
		item_ch.tile_value_bits <= it.tile_val;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		predict_merge(it);
	endtask

	function automatic merge_item_t make_header(input logic [31:0] mo, input logic [31:0] so,
		input logic [31:0] mt, input logic [31:0] st);
		merge_item_t it;
		it.op = OP_HEADER;
		it.old_max = mo;
		it.old_sum = so;
		it.tile_max = mt;
		it.tile_sum = st;
		it.old_val = $urandom;
		it.tile_val = $urandom;
		return it;
	endfunction

	function automatic merge_item_t make_element(input logic [31:0] vo, input logic [31:0] vt);
		merge_item_t it;
		it.op = OP_ELEMENT;
		it.old_max = $urandom;
		it.old_sum = $urandom;
		it.tile_max = $urandom;
		it.tile_sum = $urandom;
		it.old_val = vo;
		it.tile_val = vt;
		return it;
	endfunction

	function automatic logic [31:0] rand_float(input int elo, input int ehi, input logic sgn);
		return {sgn, 8'($urandom_range(elo, ehi)), 23'($urandom)};
	endfunction

	task automatic test_directed();
		send_item(make_element(32'h3f800000, 32'hbf800000));
		send_item(make_header(32'h3f800000, 32'h40000000, 32'h40000000, 32'h3f800000));
		send_item(make_element(32'h3f800000, 32'h40400000));
		send_item(make_element(32'hffffffff, 32'h7fffffff));
		send_item(make_element(32'h00000000, 32'h80000000));
		send_item(make_header(QNAN, 32'h3f800000, 32'h3f000000, 32'h3f800000));
		send_item(make_header(32'h3f000000, 32'h3f800000, QNAN, 32'h3f800000));
		send_item(make_header(32'h40a00000, 32'h41200000, 32'h40a00000, 32'h40000000));
		send_item(make_header(32'h80000000, 32'h3f800000, 32'h00000000, 32'h3f800000));
		send_item(make_header(POS_INF, 32'h3f800000, 32'h3f800000, POS_INF));
		send_item(make_header(32'h00000001, 32'h007fffff, 32'h80400000, 32'h3f800000));
		send_item(make_element(32'h007fffff, 32'h00000001));
		send_item(make_header(32'h41400000, 32'h42000000, 32'h3f800000, 32'h42800000));
		send_item(make_header(32'h41000000, 32'h3f800000, 32'h00000000, 32'h3f800000));
		send_item(make_element(32'h46fffe00, 32'hc6fffe00));
		send_item(make_header(32'h3f800000, 32'h00000000, 32'h3f800000, 32'h00000000));
		send_item(make_element(32'h3f800000, 32'h3f800000));
		send_item(make_header(32'h3f800000, 32'h47000000, 32'h3f800000, 32'h47000000));
		send_item(make_element(32'h47000000, 32'hc7000000));
		send_item(make_header(32'h00000000, 32'h33800000, 32'h00000000, 32'h2f800000));
		send_item(make_element(32'h3f800000, 32'h3f800000));
		send_item(make_header(32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h7fffffff));
		send_item(make_element(32'hffffffff, 32'hffffffff));
	endtask

	task automatic test_random(input int count);
		int          sent;
		int          n_elem;
		logic [31:0] mo;
		logic [31:0] mt;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 85) begin
				mo = rand_float(118, 130, $urandom_range(0, 1));
				mt = ($urandom_range(0, 3) == 0) ? mo : rand_float(118, 130, $urandom_range(0, 1));
				send_item(make_header(mo, rand_float(110, 140, 1'b0), mt,
					rand_float(110, 140, $urandom_range(0, 9) == 0)));
				n_elem = $urandom_range(1, 8);
				for (int i = 0; i < n_elem; i++) begin
					send_item(make_element(rand_float(105, 140, $urandom_range(0, 1)),
						rand_float(105, 140, $urandom_range(0, 1))));
				end
				sent += n_elem + 1;
			end else begin
				if ($urandom_range(0, 1)) send_item(make_header($urandom, $urandom, $urandom, $urandom));
				else send_item(make_element($urandom, $urandom));
				sent++;
			end
		end
	endtask

	task automatic test_drain_pause();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		send_item(make_header(32'h3f800000, 32'h3f800000, 32'h3f000000, 32'h40000000));
		send_item(make_element(32'h40000000, 32'hc0000000));
	endtask

	always @(posedge clk) begin
		merge_result_t exp_r;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer");
				failures++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_ch.result_kind !== exp_r.kind) begin
					$error("result_kind expected %h actual %h", exp_r.kind, result_ch.result_kind);
					failures++;
				end
				if (result_ch.new_max_bits !== exp_r.new_max) begin
					$error("new_max_bits expected %h actual %h", exp_r.new_max,
						result_ch.new_max_bits);
					failures++;
				end
				if (result_ch.new_sum_bits !== exp_r.new_sum) begin
					$error("new_sum_bits expected %h actual %h", exp_r.new_sum,
						result_ch.new_sum_bits);
					failures++;
				end
				if (result_ch.merged_value_bits !== exp_r.merged) begin
					$error("merged_value_bits expected %h actual %h", exp_r.merged,
						result_ch.merged_value_bits);
					failures++;
				end
			end
		end
		result_ch.ready <= arst_n && ($urandom_range(0, 99) >= snk_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		failures = 0;
		old_w = 64'd0;
		tile_w = 64'd0;
		src_idle = 31;
		snk_idle = 78;
		arst_n = 1'b0;
		result_ch.ready = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_HEADER;
		item_ch.old_max_bits = '0;
		item_ch.old_sum_bits = '0;
		item_ch.tile_max_bits = '0;
		item_ch.tile_sum_bits = '0;
		item_ch.old_value_bits = '0;
		item_ch.tile_value_bits = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(580);
		test_drain_pause();
		src_idle = 78;
		snk_idle = 31;
		test_random(580);
		src_idle = 0;
		snk_idle = 0;
		test_random(600);
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
